[rtl/core/pfb_pkg.sv]
// Package: shared types, constants and a mask helper for the page framebuffer blit engine.
package pfb_pkg;

  localparam logic [7:0] BYTE_ONES = 8'hFF;
  localparam logic [7:0] ROW_CAP   = 8'd255;

  // Command codes; codes above FUNC_READ carry no meaning
  typedef enum logic [2:0] {
    FUNC_OPEN   = 3'd0,
    FUNC_WRITE  = 3'd1,
    FUNC_INVERT = 3'd2,
    FUNC_FILL   = 3'd3,
    FUNC_READ   = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_WR,
    S_RESP
  } state_t;

  // Bits of one page byte covered by an invert row starting at bit sh
  // with rem pixel rows still to go
  function automatic logic [7:0] row_mask(input logic [2:0] sh, input logic [6:0] rem);
    logic [3:0] run;
    logic [7:0] m;
    run = 4'd8 - {1'b0, sh};
    m   = BYTE_ONES << sh;
    if (rem < {3'b000, run}) begin
      m = m & (BYTE_ONES >> (run - rem[3:0]));
    end
    return m;
  endfunction

endpackage

[rtl/core/pfb_cmd_if.sv]
// Interface: command channel of the page framebuffer blit engine.
interface pfb_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [6:0]  x;
  logic [5:0]  y;
  logic [7:0]  width;
  logic [6:0]  height;
  logic [10:0] count;
  logic [7:0]  value;

  modport source (output valid, func, x, y, width, height, count, value, input ready);
  modport sink   (input valid, func, x, y, width, height, count, value, output ready);
endinterface

[rtl/core/pfb_res_if.sv]
// Interface: result channel of the page framebuffer blit engine.
interface pfb_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic [10:0] bytes_left;
  logic        dropped;

  modport source (output valid, read_data, bytes_left, dropped, input ready);
  modport sink   (input valid, read_data, bytes_left, dropped, output ready);
endinterface

[rtl/core/pfb_ram.sv]
// Generic single-port RAM with registered read data.
module pfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on we, read every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[rtl/core/page_framebuffer_blit_engine.sv]
// Top level: page framebuffer with window writes, rectangle invert/fill and byte reads.
//
//  channel | modport     | beat
//  --------+-------------+-------------------------------------------------
//  cmd     | pfb_cmd_if  | func, x, y, width, height, count, value
//  res     | pfb_res_if  | read_data, bytes_left, dropped (one per command)
//
// One command at a time; cmd.ready is high only while the sequencer is idle.
// open_window, unused codes and write_byte with no window or zero width go straight to the
// result; read_byte reads one byte; write_byte merges one page byte, or two when the row is
// not page-aligned; invert/fill merge each byte of the rectangle. Bytes outside the buffer
// are skipped and flagged; all is paced by the single frame store port (read, then write).
// After reset a clearing pass writes zero to all PAGES*COLUMNS bytes, one per cycle.
// A stalled result holds in the output register; the next command's result waits behind it.
module page_framebuffer_blit_engine #(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8
) (
  input  logic      clk,
  input  logic      rst,
  pfb_cmd_if.sink   cmd,
  pfb_res_if.source res
);
  import pfb_pkg::*;

  localparam int DEPTH = PAGES * COLUMNS;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  state_t state, state_next;
  func_t  op, op_next;

  // Clearing pass
  logic [AW-1:0] clr_idx, clr_idx_next;

  // Walk registers
  logic [7:0] wpage, wpage_next;
  logic [8:0] wcol, wcol_next;
  logic [2:0] wsh, wsh_next;
  logic [6:0] wrem, wrem_next;
  logic [7:0] ccnt, ccnt_next;
  logic [6:0] xbase, xbase_next;
  logic [7:0] wwidth, wwidth_next;
  logic [7:0] wval, wval_next;
  logic       second, second_next;
  logic       drop, drop_next;
  logic [7:0] rd, rd_next;

  // Window cursor
  logic [8:0]  cur_col, cur_col_next;
  logic [6:0]  win_start, win_start_next;
  logic [7:0]  win_width, win_width_next;
  logic [7:0]  cols_left, cols_left_next;
  logic [7:0]  cur_row, cur_row_next;
  logic [10:0] bytes_left, bytes_left_next;

  // Result register
  logic        out_valid, out_valid_next;
  logic [7:0]  out_rd, out_rd_next;
  logic [10:0] out_left, out_left_next;
  logic        out_drop, out_drop_next;

  // Frame store port
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;

  // Access datapath
  logic [AW-1:0] acc_addr;
  logic          acc_in_buf;
  logic [3:0]    shl;
  logic [7:0]    keep, bits, flip, merged;
  logic [3:0]    run;
  logic [6:0]    rem_after;
  logic [7:0]    cols_dec;
  logic [8:0]    row_sum;
  logic          do_adv;

  pfb_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign cmd.ready     = (state == S_IDLE);
  assign res.valid     = out_valid;
  assign res.read_data = out_rd;
  assign res.bytes_left = out_left;
  assign res.dropped   = out_drop;

  // Address and bounds of the current access
  assign acc_addr   = AW'(wpage) * AW'(COLUMNS) + AW'(wcol);
  assign acc_in_buf = ({1'b0, wpage} < 9'(PAGES)) && (wcol < 9'(COLUMNS));

  // Merge masks for the current access
  assign shl = 4'd8 - {1'b0, wsh};
  always_comb begin
    keep = BYTE_ONES;
    bits = 8'h00;
    flip = 8'h00;
    unique case (op)
      FUNC_WRITE: begin
        if (second) begin
          keep = BYTE_ONES << wsh;
          bits = wval >> shl;
        end else begin
          keep = (wsh == 3'd0) ? 8'h00 : (BYTE_ONES >> shl);
          bits = wval << wsh;
        end
      end
      FUNC_INVERT: flip = row_mask(wsh, wrem);
      FUNC_FILL: begin
        keep = 8'h00;
        bits = wval;
      end
      default: ;
    endcase
  end
  assign merged = ((ram_rdata & keep) | bits) ^ flip;

  // Rows left after the current row of a rectangle
  assign run = 4'd8 - {1'b0, wsh};
  always_comb begin
    if (op == FUNC_FILL) begin
      rem_after = wrem - 7'd1;
    end else if (wrem > {3'b000, run}) begin
      rem_after = wrem - {3'b000, run};
    end else begin
      rem_after = 7'd0;
    end
  end

  assign cols_dec = cols_left - 8'd1;
  assign row_sum  = {1'b0, cur_row} + 9'd8;

  // Sequencer: next state and datapath control
  always_comb begin
    state_next      = state;
    op_next         = op;
    clr_idx_next    = clr_idx;
    wpage_next      = wpage;
    wcol_next       = wcol;
    wsh_next        = wsh;
    wrem_next       = wrem;
    ccnt_next       = ccnt;
    xbase_next      = xbase;
    wwidth_next     = wwidth;
    wval_next       = wval;
    second_next     = second;
    drop_next       = drop;
    rd_next         = rd;
    cur_col_next    = cur_col;
    win_start_next  = win_start;
    win_width_next  = win_width;
    cols_left_next  = cols_left;
    cur_row_next    = cur_row;
    bytes_left_next = bytes_left;
    out_valid_next  = out_valid;
    out_rd_next     = out_rd;
    out_left_next   = out_left;
    out_drop_next   = out_drop;
    ram_we          = 1'b0;
    ram_addr        = acc_addr;
    ram_wdata       = merged;
    do_adv          = 1'b0;

    // Release a taken result
    if (out_valid && res.ready) begin
      out_valid_next = 1'b0;
    end

    unique case (state)
      S_CLEAR: begin
        ram_we       = 1'b1;
        ram_addr     = clr_idx;
        ram_wdata    = 8'h00;
        clr_idx_next = clr_idx + AW'(1);
        if (clr_idx == LAST_ADDR) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (cmd.valid) begin
          op_next     = func_t'(cmd.func);
          drop_next   = 1'b0;
          rd_next     = 8'h00;
          second_next = 1'b0;
          wval_next   = cmd.value;
          xbase_next  = cmd.x;
          wwidth_next = cmd.width;
          wcol_next   = {2'b00, cmd.x};
          ccnt_next   = cmd.width;
          state_next  = S_RESP;
          unique case (cmd.func)
            FUNC_OPEN: begin
              win_start_next  = cmd.x;
              cur_col_next    = {2'b00, cmd.x};
              win_width_next  = cmd.width;
              cols_left_next  = cmd.width;
              cur_row_next    = {2'b00, cmd.y};
              bytes_left_next = cmd.count;
            end
            FUNC_WRITE: begin
              if (bytes_left == 11'd0) begin
                drop_next = 1'b1;
              end else begin
                bytes_left_next = bytes_left - 11'd1;
                if (win_width == 8'd0) begin
                  drop_next = 1'b1;
                end else begin
                  wpage_next = {3'b000, cur_row[7:3]};
                  wsh_next   = cur_row[2:0];
                  wcol_next  = cur_col;
                  state_next = S_RD;
                  // Advance the cursor, wrapping to the next page row at row end
                  if (cols_dec == 8'd0) begin
                    cur_row_next   = (row_sum > {1'b0, ROW_CAP}) ? ROW_CAP : row_sum[7:0];
                    cur_col_next   = {2'b00, win_start};
                    cols_left_next = win_width;
                  end else begin
                    cur_col_next   = cur_col + 9'd1;
                    cols_left_next = cols_dec;
                  end
                end
              end
            end
            FUNC_INVERT: begin
              wpage_next = {5'b00000, cmd.y[5:3]};
              wsh_next   = cmd.y[2:0];
              wrem_next  = cmd.height;
              if (cmd.width != 8'd0 && cmd.height != 7'd0) begin
                state_next = S_RD;
              end
            end
            FUNC_FILL: begin
              wpage_next = {5'b00000, cmd.y[5:3]};
              wsh_next   = 3'd0;
              wrem_next  = cmd.height;
              if (cmd.width != 8'd0 && cmd.height != 7'd0) begin
                state_next = S_RD;
              end
            end
            FUNC_READ: begin
              wpage_next = {5'b00000, cmd.y[5:3]};
              state_next = S_RD;
            end
            default: ;
          endcase
        end
      end

      S_RD: begin
        // Read is issued at acc_addr; skip bytes outside the buffer
        if (acc_in_buf) begin
          state_next = S_WR;
        end else begin
          drop_next = 1'b1;
          do_adv    = 1'b1;
        end
      end

      S_WR: begin
        if (op == FUNC_READ) begin
          rd_next    = ram_rdata;
          state_next = S_RESP;
        end else begin
          ram_we = 1'b1;
          do_adv = 1'b1;
        end
      end

      S_RESP: begin
        if (!out_valid || res.ready) begin
          out_valid_next = 1'b1;
          out_rd_next    = rd;
          out_left_next  = bytes_left;
          out_drop_next  = drop;
          state_next     = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase

    // Advance the walk after one byte
    if (do_adv) begin
      priority if (op == FUNC_WRITE) begin
        if (wsh != 3'd0 && !second) begin
          second_next = 1'b1;
          wpage_next  = wpage + 8'd1;
          state_next  = S_RD;
        end else begin
          state_next = S_RESP;
        end
      end else if (op == FUNC_INVERT || op == FUNC_FILL) begin
        if (ccnt > 8'd1) begin
          ccnt_next  = ccnt - 8'd1;
          wcol_next  = wcol + 9'd1;
          state_next = S_RD;
        end else if (rem_after == 7'd0) begin
          state_next = S_RESP;
        end else begin
          wrem_next  = rem_after;
          wpage_next = wpage + 8'd1;
          wsh_next   = 3'd0;
          wcol_next  = {2'b00, xbase};
          ccnt_next  = wwidth;
          state_next = S_RD;
        end
      end else begin
        state_next = S_RESP;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_idx    <= '0;
      out_valid  <= 1'b0;
      cur_col    <= '0;
      win_start  <= '0;
      win_width  <= '0;
      cols_left  <= '0;
      cur_row    <= '0;
      bytes_left <= '0;
    end else begin
      state      <= state_next;
      clr_idx    <= clr_idx_next;
      out_valid  <= out_valid_next;
      cur_col    <= cur_col_next;
      win_start  <= win_start_next;
      win_width  <= win_width_next;
      cols_left  <= cols_left_next;
      cur_row    <= cur_row_next;
      bytes_left <= bytes_left_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op       <= op_next;
    wpage    <= wpage_next;
    wcol     <= wcol_next;
    wsh      <= wsh_next;
    wrem     <= wrem_next;
    ccnt     <= ccnt_next;
    xbase    <= xbase_next;
    wwidth   <= wwidth_next;
    wval     <= wval_next;
    second   <= second_next;
    drop     <= drop_next;
    rd       <= rd_next;
    out_rd   <= out_rd_next;
    out_left <= out_left_next;
    out_drop <= out_drop_next;
  end

endmodule
